// ===== hdl/nibp_pkg.sv =====
// Package for the NOR-indexed branch predictor: sizes, function codes,
// counter write-port struct and the table index function.
// No dependencies.
`timescale 1ns / 1ps

package nibp_pkg;

	localparam int TABLE_ENTRIES     = 256;
	localparam int COUNTER_BITS      = 2;
	localparam int THREADS           = 4;
	localparam int INSTRUCTION_SHIFT = 2;

	localparam int IDX_W    = $clog2(TABLE_ENTRIES);
	localparam int FUNC_W   = 3;
	localparam int THREAD_W = 2;
	localparam int ADDR_W   = 64;
	localparam int HFIELD_W = 8;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [COUNTER_BITS-1:0] ctr_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_LOOKUP   = 3'd0,
		FN_UPDATE   = 3'd1,
		FN_RESTORE  = 3'd2,
		FN_UNCOND   = 3'd3,
		FN_BTB_MISS = 3'd4
	} func_t;

	typedef struct packed {
		logic en;
		idx_t addr;
		ctr_t data;
	} ctr_wr_t;

	// NOR of low address and history bits; both operands zero maps to entry 1
	function automatic idx_t table_index(input logic [ADDR_W-1:0] addr,
			input logic [HFIELD_W-1:0] hist);
		logic [31:0] a;
		a = addr[INSTRUCTION_SHIFT +: 32];
		if (a == 32'd0 && hist == '0) begin
			return IDX_W'(1);
		end
		return IDX_W'(~(a[HFIELD_W-1:0] | hist));
	endfunction

endpackage

// ===== hdl/nibp_table.sv =====
// Direction counter table: one write and one registered read per cycle,
// valid bits so unwritten entries read as zero, write-to-read bypass.
// Depends on nibp_pkg.
`timescale 1ns / 1ps

module nibp_table (
	input  logic              clk,
	input  logic              arst_n,
	input  nibp_pkg::idx_t    rd_addr,
	input  nibp_pkg::ctr_wr_t wr,
	output nibp_pkg::ctr_t    rd_data
);
	import nibp_pkg::*;

	ctr_t                     mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	ctr_t                     rd_mem_s1;
	logic                     rd_vld_s1;
	logic                     fwd_s1;
	ctr_t                     fwd_data_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_mem_s1   <= mem[rd_addr];
		fwd_data_s1 <= wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
			fwd_s1    <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			rd_vld_s1 <= valid_q[rd_addr];
			// same-edge write to the entry being read: take the new word
			fwd_s1    <= wr.en && (wr.addr == rd_addr);
		end
	end

	assign rd_data = fwd_s1 ? fwd_data_s1 : (rd_vld_s1 ? rd_mem_s1 : '0);

endmodule

// ===== hdl/nor_indexed_branch_predictor_top.sv =====
// NOR-indexed branch predictor top: per-thread history, counter table access.
// Timing: a word accepted with start is registered into stage 1 with its
// table read; its results are then registered onto the result ports, with
// done high for one cycle. Throughput: one word per cycle; busy is always
// low. The table read at the accept edge and the stage-1 history update set this rate.
// Reset: histories, valid bits and strobes clear at once; no clearing pass.
// Depends on nibp_pkg and nibp_table.
`timescale 1ns / 1ps

module nor_indexed_branch_predictor_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [nibp_pkg::FUNC_W-1:0]     func,
	input  logic [nibp_pkg::THREAD_W-1:0]   thread,
	input  logic [nibp_pkg::ADDR_W-1:0]     branch_address,
	input  logic                            taken,
	input  logic                            squashed,
	input  logic [nibp_pkg::HFIELD_W-1:0]   saved_history,
	output logic                            done,
	output logic                            prediction,
	output logic [nibp_pkg::HFIELD_W-1:0]   history_snapshot
);
	import nibp_pkg::*;

	idx_t                  history_q [THREADS];
	idx_t                  hist_nx   [THREADS];

	logic                  v_s1;
	func_t                 func_s1;
	logic [THREAD_W-1:0]   thread_s1;
	logic                  taken_s1;
	logic                  squashed_s1;
	logic [HFIELD_W-1:0]   saved_s1;
	idx_t                  idx_s1;

	idx_t                  rd_idx;
	ctr_t                  ctr;
	ctr_wr_t               wr;
	logic                  thread_ok;
	logic                  pred;
	idx_t                  hist_cur;
	idx_t                  hist_new;
	logic                  hist_we;

	logic                  done_q;
	logic                  prediction_q;
	logic [HFIELD_W-1:0]   snapshot_q;

	assign busy = 1'b0;

	nibp_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_idx),
		.wr      (wr),
		.rd_data (ctr)
	);

	assign thread_ok = int'(thread_s1) < THREADS;
	assign pred      = ctr[COUNTER_BITS-1];
	assign hist_cur  = history_q[thread_s1];

	always_comb begin
		hist_new = hist_cur;
		hist_we  = 1'b0;
		if (v_s1 && thread_ok) begin
			case (func_s1)
				FN_LOOKUP: begin
					hist_new = IDX_W'({hist_cur, pred});
					hist_we  = 1'b1;
				end
				FN_UPDATE: begin
					hist_new = IDX_W'({saved_s1, taken_s1});
					hist_we  = squashed_s1;
				end
				FN_RESTORE: begin
					hist_new = IDX_W'(saved_s1);
					hist_we  = 1'b1;
				end
				FN_UNCOND: begin
					hist_new = IDX_W'({hist_cur, 1'b1});
					hist_we  = 1'b1;
				end
				FN_BTB_MISS: begin
					hist_new = hist_cur & ~IDX_W'(1);
					hist_we  = 1'b1;
				end
				default: begin
					hist_we = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		hist_nx = history_q;
		if (hist_we) begin
			hist_nx[thread_s1] = hist_new;
		end
	end

	// lookup indexes with the history as the word in flight leaves it
	always_comb begin
		if (func == FN_LOOKUP) begin
			rd_idx = table_index(branch_address, HFIELD_W'(hist_nx[thread]));
		end else begin
			rd_idx = table_index(branch_address, saved_history);
		end
	end

	always_comb begin
		wr.en   = v_s1 && thread_ok && (func_s1 == FN_UPDATE) && !squashed_s1;
		wr.addr = idx_s1;
		wr.data = ctr;
		if (taken_s1) begin
			if (ctr != '1) begin
				wr.data = ctr + COUNTER_BITS'(1);
			end
		end else begin
			if (ctr != '0) begin
				wr.data = ctr - COUNTER_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		func_s1     <= func_t'(func);
		thread_s1   <= thread;
		taken_s1    <= taken;
		squashed_s1 <= squashed;
		saved_s1    <= saved_history;
		idx_s1      <= rd_idx;
		if (thread_ok && func_s1 == FN_LOOKUP) begin
			prediction_q <= pred;
			snapshot_q   <= HFIELD_W'(hist_cur);
		end else if (thread_ok && func_s1 == FN_UNCOND) begin
			prediction_q <= 1'b0;
			snapshot_q   <= HFIELD_W'(hist_cur);
		end else begin
			prediction_q <= 1'b0;
			snapshot_q   <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < THREADS; i++) begin
				history_q[i] <= '0;
			end
		end else begin
			v_s1      <= start && !busy;
			done_q    <= v_s1;
			history_q <= hist_nx;
		end
	end

	assign done             = done_q;
	assign prediction       = prediction_q;
	assign history_snapshot = snapshot_q;

endmodule
